// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the depth pixel to point transform.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/dpt_pkg.sv =====
// Shared types and constants of the depth pixel to point transform.
// No dependencies; imported by dpt_row and the top level.
package dpt_pkg;

	localparam int COEF_W   = 16;
	localparam int ROW_W    = 3 * COEF_W;
	localparam int POINT_W  = 32;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z = 3'd5;

	// Identity transform after reset.
	localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_4000;
	localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h4000_0000_0000;

	// Scaling to metres divides by 4096 * 1000: a shift, then a divide by 1000
	// done as a multiply by a truncated reciprocal and one correction step.
	localparam int DIV_SHIFT   = 12;
	localparam int DIV_BASE    = 1000;
	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_W     = 27;
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_BASE);

	// Cycles from an accepted pixel to its result strobe.
	localparam int PIPE_LAT = 7;

	typedef struct packed {
		logic       keep;
		logic       last;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} tag_t;

endpackage

// ===== rtl/dpt_row.sv =====
// One output coordinate of the transform: dot product with the ray, depth
// multiply, scaling to metres, offset and saturation in seven stages. Uses dpt_pkg.
module dpt_row import dpt_pkg::*; (
	input  logic                      clk,
	input  logic [ROW_W-1:0]          coef,
	input  logic signed [POINT_W-1:0] offset,
	input  logic [15:0]               depth_mm,
	input  logic signed [15:0]        ray_x,
	input  logic signed [15:0]        ray_y,
	input  logic                      drop_s6,
	output logic signed [POINT_W-1:0] point
);

	logic signed [COEF_W-1:0] cx, cy, cz;

	logic signed [31:0] px_s1, py_s1;
	logic signed [15:0] cz_s1;
	logic [15:0]        d_s1;

	logic signed [32:0] t_s2;
	logic [15:0]        d_s2;

	logic signed [49:0] s_s3;

	logic [37:0]        q_full;
	logic [37:0]        u_full;
	logic [44:0]        ph_s4, pl_s4;
	logic [35:0]        u_s4;
	logic               neg_s4;

	logic [62:0]        prod;
	logic [RECIP_W-1:0] qest_s5;
	logic [35:0]        u_s5;
	logic               neg_s5;

	logic [35:0]        rem;
	logic [RECIP_W-1:0] qfix;
	logic signed [27:0] quo_s6;

	logic signed [32:0] sum;
	logic signed [POINT_W-1:0] pt_s7;

	assign cx = coef[15:0];
	assign cy = coef[31:16];
	assign cz = coef[47:32];

	always_ff @(posedge clk) begin
		px_s1 <= cx * ray_x;
		py_s1 <= cy * ray_y;
		cz_s1 <= cz;
		d_s1  <= depth_mm;
	end

	always_ff @(posedge clk) begin
		t_s2 <= 33'(px_s1) + 33'(py_s1) + $signed({{3{cz_s1[15]}}, cz_s1, 14'b0});
		d_s2 <= d_s1;
	end

	always_ff @(posedge clk) begin
		s_s3 <= t_s2 * $signed({1'b0, d_s2});
	end

	// The arithmetic shift floors the divide by 4096. A negative value is
	// folded to its complement so the divide by 1000 works on a magnitude.
	assign q_full = s_s3[49:DIV_SHIFT];
	assign u_full = q_full[37] ? ~q_full : q_full;

	always_ff @(posedge clk) begin
		ph_s4  <= 45'(u_full[35:18]) * 45'(DIV_RECIP);
		pl_s4  <= 45'(u_full[17:0]) * 45'(DIV_RECIP);
		u_s4   <= u_full[35:0];
		neg_s4 <= q_full[37];
	end

	assign prod = {ph_s4, 18'b0} + 63'(pl_s4);

	always_ff @(posedge clk) begin
		qest_s5 <= prod[62:RECIP_SHIFT];
		u_s5    <= u_s4;
		neg_s5  <= neg_s4;
	end

	// The estimate is exact or one short of the true quotient.
	assign rem  = u_s5 - 36'(qest_s5) * 36'(DIV_BASE);
	assign qfix = qest_s5 + RECIP_W'(rem >= 36'(DIV_BASE));

	always_ff @(posedge clk) begin
		quo_s6 <= neg_s5 ? ~{1'b0, qfix} : {1'b0, qfix};
	end

	assign sum = 33'(quo_s6) + 33'(offset);

	always_ff @(posedge clk) begin
		if (drop_s6) begin
			pt_s7 <= '0;
		end else if (sum[32] != sum[31]) begin
			pt_s7 <= sum[32] ? {1'b1, {(POINT_W-1){1'b0}}} : {1'b0, {(POINT_W-1){1'b1}}};
		end else begin
			pt_s7 <= sum[31:0];
		end
	end

	assign point = pt_s7;

endmodule

// ===== rtl/depth_pixel_to_point_transform_core.sv =====
// Top level of the depth pixel to point transform: configuration registers,
// pixel tag pipeline and three dpt_row lanes. Uses dpt_pkg and assert_macros.svh.
//
// Usage:
// A pixel is taken at each rising edge where start is high; busy is always
// low, so a new pixel may be offered in every cycle. Pixels with zero depth
// or an invalid ray are dropped, except a frame's last pixel, which always
// gives a word with frame_end set (point_valid low and all fields zero when
// the pixel was dropped).
// Each result word appears with done high for exactly one cycle; one word per
// clock is sustained. Each coordinate lane has seven register stages: ray
// products, sum, depth multiply, split reciprocal multiply, quotient estimate,
// quotient fix, and offset with saturation. The receiver cannot stall the
// block, and results keep the order of their pixels.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; an index beyond the six registers is ignored. Write it only
// while no pixel is in flight.
// Reset clears the valid chain and loads the identity transform with zero offset.
`include "assert_macros.svh"

module depth_pixel_to_point_transform_core import dpt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      start,
	output logic                      busy,
	input  logic [15:0]               depth_mm,
	input  logic signed [15:0]        ray_x,
	input  logic signed [15:0]        ray_y,
	input  logic                      ray_valid,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic                      last_pixel,

	output logic                      done,
	output logic signed [POINT_W-1:0] point_x,
	output logic signed [POINT_W-1:0] point_y,
	output logic signed [POINT_W-1:0] point_z,
	output logic [7:0]                out_red,
	output logic [7:0]                out_green,
	output logic [7:0]                out_blue,
	output logic                      point_valid,
	output logic                      frame_end,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [ROW_W-1:0]          cfg_data
);

	logic [ROW_W-1:0]          row_x_q, row_y_q, row_z_q;
	logic signed [POINT_W-1:0] off_x_q, off_y_q, off_z_q;

	logic           keep;
	tag_t           tag_in;
	logic [PIPE_LAT:1] vld_s;
	tag_t           tag_s [1:PIPE_LAT];

	logic           empty_word;
	logic           marker_word;
	logic           marker_clear;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= ROW_X_RESET;
			row_y_q <= ROW_Y_RESET;
			row_z_q <= ROW_Z_RESET;
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_X: row_x_q <= cfg_data;
				CFG_ROW_Y: row_y_q <= cfg_data;
				CFG_ROW_Z: row_z_q <= cfg_data;
				CFG_OFF_X: off_x_q <= cfg_data[POINT_W-1:0];
				CFG_OFF_Y: off_y_q <= cfg_data[POINT_W-1:0];
				CFG_OFF_Z: off_z_q <= cfg_data[POINT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign keep = (depth_mm != 16'd0) && ray_valid;

	assign tag_in = '{keep: keep, last: last_pixel, red: red, green: green, blue: blue};

	// Only pixels that give a word enter the valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[PIPE_LAT-1:1], start && !busy && (keep || last_pixel)};
		end
	end

	always_ff @(posedge clk) begin
		tag_s[1] <= tag_in;
		for (int i = 2; i <= PIPE_LAT; i++) begin
			tag_s[i] <= tag_s[i-1];
		end
	end

	dpt_row u_row_x (
		.clk      (clk),
		.coef     (row_x_q),
		.offset   (off_x_q),
		.depth_mm (depth_mm),
		.ray_x    (ray_x),
		.ray_y    (ray_y),
		.drop_s6  (!tag_s[PIPE_LAT-1].keep),
		.point    (point_x)
	);

	dpt_row u_row_y (
		.clk      (clk),
		.coef     (row_y_q),
		.offset   (off_y_q),
		.depth_mm (depth_mm),
		.ray_x    (ray_x),
		.ray_y    (ray_y),
		.drop_s6  (!tag_s[PIPE_LAT-1].keep),
		.point    (point_y)
	);

	dpt_row u_row_z (
		.clk      (clk),
		.coef     (row_z_q),
		.offset   (off_z_q),
		.depth_mm (depth_mm),
		.ray_x    (ray_x),
		.ray_y    (ray_y),
		.drop_s6  (!tag_s[PIPE_LAT-1].keep),
		.point    (point_z)
	);

	assign done        = vld_s[PIPE_LAT];
	assign point_valid = vld_s[PIPE_LAT] && tag_s[PIPE_LAT].keep;
	assign frame_end   = vld_s[PIPE_LAT] && tag_s[PIPE_LAT].last;
	assign out_red     = tag_s[PIPE_LAT].keep ? tag_s[PIPE_LAT].red   : 8'd0;
	assign out_green   = tag_s[PIPE_LAT].keep ? tag_s[PIPE_LAT].green : 8'd0;
	assign out_blue    = tag_s[PIPE_LAT].keep ? tag_s[PIPE_LAT].blue  : 8'd0;

	assign empty_word   = done && !point_valid && !frame_end;
	assign marker_word  = done && !point_valid;
	assign marker_clear = (point_x == 32'sd0) && (point_y == 32'sd0) && (point_z == 32'sd0)
		&& (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0);

	// A dropped pixel reaches the output only as a frame-end marker.
	`ASSERT_NEVER(a_no_empty_word, clk, arst_n, empty_word, "word with neither point nor frame end")

	// The marker for a dropped last pixel carries an all-zero point and colour.
	`ASSERT_IMPLY(a_marker_zero, clk, arst_n, marker_word, marker_clear, "marker carries data")

endmodule

// ===== test/tb_depth_pixel_to_point_transform_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for depth_pixel_to_point_transform_core: drives pixels and transform
// settings, predicts every output word and compares it field by field. Depends on dpt_pkg.
import dpt_pkg::*;

typedef struct packed {
	logic [15:0]        depth;
	logic signed [15:0] rx;
	logic signed [15:0] ry;
	logic               ray_ok;
	logic [7:0]         r;
	logic [7:0]         g;
	logic [7:0]         b;
	logic               last;
} pixel_t;

typedef struct packed {
	logic signed [POINT_W-1:0] x;
	logic signed [POINT_W-1:0] y;
	logic signed [POINT_W-1:0] z;
	logic [7:0]                r;
	logic [7:0]                g;
	logic [7:0]                b;
	logic                      valid;
	logic                      fe;
} point_t;

class point_board;
	localparam longint MM_TO_Q16_DIV = 4096000;
	localparam longint UNIT_Q14 = 16384;

	logic [ROW_W-1:0] rows [3];
	logic [31:0]      offs [3];
	point_t           expected_points [$];
	int               errors;

	function new();
		rows[0] = ROW_X_RESET;
		rows[1] = ROW_Y_RESET;
		rows[2] = ROW_Z_RESET;
		offs[0] = '0;
		offs[1] = '0;
		offs[2] = '0;
		errors = 0;
	endfunction

	function void note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%t mismatch: %s", $realtime, msg);
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		case (idx)
			CFG_ROW_X: rows[0] = data;
			CFG_ROW_Y: rows[1] = data;
			CFG_ROW_Z: rows[2] = data;
			CFG_OFF_X: offs[0] = data[31:0];
			CFG_OFF_Y: offs[1] = data[31:0];
			CFG_OFF_Z: offs[2] = data[31:0];
			default: ;
		endcase
	endfunction

	// One output axis: exact sum in 2^-28 mm, floored to Q16.16 metres, offset, saturated.
	function logic signed [POINT_W-1:0] project_axis(int axis, pixel_t p);
		longint cx, cy, cz, rx, ry, d, acc, q;
		cx = longint'($signed(rows[axis][15:0]));
		cy = longint'($signed(rows[axis][31:16]));
		cz = longint'($signed(rows[axis][47:32]));
		rx = longint'($signed(p.rx));
		ry = longint'($signed(p.ry));
		d = longint'({1'b0, p.depth});
		acc = cx * rx * d + cy * ry * d + cz * UNIT_Q14 * d;
		q = acc / MM_TO_Q16_DIV;
		if (acc % MM_TO_Q16_DIV != 0 && acc < 0)
			q = q - 1;
		q = q + longint'($signed(offs[axis]));
		if (q > 64'sd2147483647)
			q = 64'sd2147483647;
		if (q < -64'sd2147483648)
			q = -64'sd2147483648;
		return q[POINT_W-1:0];
	endfunction

	function void take_pixel(pixel_t p);
		point_t w;
		logic keep;
		keep = (p.depth != 0) && p.ray_ok;
		if (!keep && !p.last)
			return;
		w = '0;
		if (keep) begin
			w.x = project_axis(0, p);
			w.y = project_axis(1, p);
			w.z = project_axis(2, p);
			w.r = p.r;
			w.g = p.g;
			w.b = p.b;
			w.valid = 1'b1;
		end
		w.fe = p.last;
		expected_points.push_back(w);
	endfunction

	function void compare(string name, longint want, longint got);
		if (want != got)
			note_error($sformatf("%s expected %0d got %0d", name, want, got));
	endfunction

	function void check_point(point_t got);
		point_t want;
		if (expected_points.size() == 0) begin
			note_error($sformatf("unexpected word %p", got));
			return;
		end
		want = expected_points.pop_front();
		compare("point_x", want.x, got.x);
		compare("point_y", want.y, got.y);
		compare("point_z", want.z, got.z);
		compare("out_red", want.r, got.r);
		compare("out_green", want.g, got.g);
		compare("out_blue", want.b, got.b);
		compare("point_valid", want.valid, got.valid);
		compare("frame_end", want.fe, got.fe);
	endfunction

	function void close_out();
		if (expected_points.size() != 0)
			note_error($sformatf("%0d words never arrived", expected_points.size()));
	endfunction
endclass

module tb_depth_pixel_to_point_transform_core;

	typedef enum {
		XF_RANDOM,
		XF_MAX,
		XF_MIN,
		XF_ZERO,
		XF_NEAR_UNIT,
		XF_ALL_ONES
	} xform_kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	pixel_t pix_q = '0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ROW_W-1:0] cfg_data = '0;

	logic busy, done, point_valid, frame_end, cfg_ready;
	logic signed [POINT_W-1:0] point_x, point_y, point_z;
	logic [7:0] out_red, out_green, out_blue;

	point_board board = new();
	bit no_gaps = 1'b0;
	int stall_cycles = 0;
	xform_kind_t phase_plan [PHASES] = '{XF_NEAR_UNIT, XF_RANDOM, XF_MAX, XF_MIN,
		XF_ZERO, XF_ALL_ONES, XF_NEAR_UNIT, XF_RANDOM};

	depth_pixel_to_point_transform_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.depth_mm(pix_q.depth),
		.ray_x(pix_q.rx),
		.ray_y(pix_q.ry),
		.ray_valid(pix_q.ray_ok),
		.red(pix_q.r),
		.green(pix_q.g),
		.blue(pix_q.b),
		.last_pixel(pix_q.last),
		.done(done),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.point_valid(point_valid),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Outputs and handshakes are sampled at the edge, before that edge's updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_point(point_t'{point_x, point_y, point_z, out_red, out_green,
					out_blue, point_valid, frame_end});
			if (start && !busy)
				board.take_pixel(pix_q);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("[depth_pixel_to_point_transform_core] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic pixel_t mk_pixel(int d, int rx, int ry, bit ok, int r, int g, int b,
		bit last);
		pixel_t p;
		p.depth = 16'(d);
		p.rx = 16'(rx);
		p.ry = 16'(ry);
		p.ray_ok = ok;
		p.r = 8'(r);
		p.g = 8'(g);
		p.b = 8'(b);
		p.last = last;
		return p;
	endfunction

	function automatic logic [15:0] pick_ray();
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return 16'h8000;
		if (sel < 10)
			return 16'h7FFF;
		if (sel < 50)
			return 16'($urandom_range(32768) - 16384);
		return 16'($urandom);
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			p.depth = '0;
		else if (sel < 16)
			p.depth = 16'hFFFF;
		else if (sel < 45)
			p.depth = 16'($urandom_range(4000, 1));
		else
			p.depth = 16'($urandom);
		p.rx = pick_ray();
		p.ry = pick_ray();
		p.ray_ok = ($urandom_range(99) < 88);
		p.r = 8'($urandom);
		p.g = 8'($urandom);
		p.b = 8'($urandom);
		p.last = ($urandom_range(99) < 8);
		return p;
	endfunction

	function automatic logic [ROW_W-1:0] pick_row(xform_kind_t kind);
		logic [ROW_W-1:0] row;
		for (int i = 0; i < 3; i++) begin
			case (kind)
				XF_RANDOM:    row[16*i +: 16] = 16'($urandom);
				XF_MAX:       row[16*i +: 16] = 16'h7FFF;
				XF_MIN:       row[16*i +: 16] = 16'h8000;
				XF_ZERO:      row[16*i +: 16] = 16'h0000;
				XF_NEAR_UNIT: row[16*i +: 16] = 16'($urandom_range(32768) - 16384);
				default:      row[16*i +: 16] = 16'hFFFF;
			endcase
		end
		return row;
	endfunction

	function automatic logic [31:0] pick_offset(xform_kind_t kind);
		case (kind)
			XF_MAX:       return 32'h7FFF_FFFF;
			XF_MIN:       return 32'h8000_0000;
			XF_NEAR_UNIT: return 32'($urandom_range(1 << 20) - (1 << 19));
			XF_ALL_ONES:  return 32'hFFFF_FFFF;
			default:      return $urandom;
		endcase
	endfunction

	task automatic send_pixel(input pixel_t p);
		if (!no_gaps)
			while ($urandom_range(99) < 20) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		pix_q <= p;
		do @(posedge clk); while (busy);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
		if (!no_gaps)
			while ($urandom_range(99) < 20) begin
				cfg_valid <= 1'b0;
				@(posedge clk);
			end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all six registers, then a word to an unused index that must change nothing.
	task automatic load_transform(input xform_kind_t kind);
		put_reg(CFG_ROW_X, pick_row(kind));
		put_reg(CFG_ROW_Y, pick_row(kind));
		put_reg(CFG_ROW_Z, pick_row(kind));
		put_reg(CFG_OFF_X, {16'($urandom), pick_offset(kind)});
		put_reg(CFG_OFF_Y, {16'($urandom), pick_offset(kind)});
		put_reg(CFG_OFF_Z, {16'($urandom), pick_offset(kind)});
		put_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, {16'($urandom), 32'($urandom)});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Dropped pixels other than a frame's last leave no word behind, so wait out the pipeline after the last one.
	task automatic settle();
		start <= 1'b0;
		while (board.expected_points.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 3) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity transform from reset.
		send_pixel(mk_pixel(65535, 32767, 32767, 1, 255, 255, 255, 0));
		send_pixel(mk_pixel(1, -32768, -32768, 1, 0, 0, 0, 0));
		send_pixel(mk_pixel(1, -1, 1, 1, 18, 52, 86, 0));
		send_pixel(mk_pixel(0, 100, 100, 1, 1, 2, 3, 0));
		send_pixel(mk_pixel(1000, 5, 5, 0, 4, 5, 6, 0));
		send_pixel(mk_pixel(0, 7, 7, 1, 9, 9, 9, 1));
		send_pixel(mk_pixel(2000, 7, 7, 0, 9, 9, 9, 1));
		send_pixel(mk_pixel(65535, -32768, 32767, 1, 170, 85, 15, 1));
		send_pixel(mk_pixel(999, 16384, -16384, 1, 128, 64, 32, 0));

		// Saturation at both ends of the output range.
		settle();
		load_transform(XF_MAX);
		send_pixel(mk_pixel(65535, 32767, 32767, 1, 255, 0, 255, 0));
		send_pixel(mk_pixel(65535, -32768, -32768, 1, 0, 255, 0, 1));
		send_pixel(mk_pixel(1, 0, 0, 1, 7, 7, 7, 0));
		settle();
		load_transform(XF_MIN);
		send_pixel(mk_pixel(65535, 32767, 32767, 1, 255, 255, 0, 0));
		send_pixel(mk_pixel(65535, -32768, -32768, 1, 0, 0, 255, 0));
		send_pixel(mk_pixel(0, 0, 0, 0, 255, 255, 255, 1));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			no_gaps = (ph == PHASES - 2);
			load_transform(phase_plan[ph]);
			repeat (100) send_pixel(rand_pixel());
		end

		settle();
		board.close_out();
		if (board.errors == 0)
			$display("[depth_pixel_to_point_transform_core] OK");
		else
			$display("[depth_pixel_to_point_transform_core] ERROR");
		$finish;
	end

endmodule
